// ===== sv/signed_int_to_decimal_ascii_core_defines.svh =====
// Assertion macros shared by the integer-to-text modules.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/itoa_pkg.sv =====
// Shared constants and types of the integer-to-text block.
package itoa_pkg;

	localparam int ValueWidth = 32;
	localparam int NumDigits  = 10;
	localparam int CntWidth   = $clog2(ValueWidth);
	localparam int RemWidth   = $clog2(NumDigits + 1);

	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] CharZero  = 8'd48;

	typedef logic [3:0] digit_t;
	typedef logic [NumDigits-1:0][3:0] digits_t;

	// Finished conversion handed from the converter to the serializer.
	typedef struct packed {
		logic    valid;
		logic    neg;
		digits_t digits;
	} bcd_res_t;

endpackage

// ===== sv/itoa_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three).
`include "signed_int_to_decimal_ascii_core_defines.svh"

module itoa_bcd (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           neg,
	input  logic [itoa_pkg::ValueWidth-1:0] mag,
	output logic                           busy,
	output itoa_pkg::bcd_res_t             res
);

	logic [itoa_pkg::ValueWidth-1:0]   bin_q;
	itoa_pkg::digits_t                 bcd_q;
	itoa_pkg::digits_t                 adj;
	logic [itoa_pkg::NumDigits*4-1:0] adj_bits;
	logic [itoa_pkg::CntWidth-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;

	// Each digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < itoa_pkg::NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// Flat view of the adjusted digits for the one-bit shift.
	assign adj_bits = adj;

	// One magnitude bit moves into the BCD register per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itoa_pkg::CntWidth'(itoa_pkg::ValueWidth - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			bin_q <= {bin_q[itoa_pkg::ValueWidth-2:0], 1'b0};
			bcd_q <= {adj_bits[itoa_pkg::NumDigits*4-2:0], bin_q[itoa_pkg::ValueWidth-1]};
		end
	end

	assign busy       = busy_q | done_q;
	assign res.valid  = done_q;
	assign res.neg    = neg_q;
	assign res.digits = bcd_q;

endmodule

// ===== sv/itoa_emit.sv =====
// Character serializer: sign, then digits without leading zeros.
`include "signed_int_to_decimal_ascii_core_defines.svh"

module itoa_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  itoa_pkg::bcd_res_t res,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char_code,
	output logic               last_char
);

	typedef enum logic [1:0] {
		IDLE,
		SIGN,
		DIGIT
	} state_t;

	state_t                        state_q;
	itoa_pkg::digits_t             dig_q;
	logic [itoa_pkg::RemWidth-1:0] rem_q;
	logic                          started_q;
	logic                          out_valid_q;
	logic [7:0]                    char_q;
	logic                          last_q;
	logic                          advance;
	itoa_pkg::digit_t              head;
	logic                          final_digit;

	assign advance     = !out_valid_q || !out_stall;
	assign head        = dig_q[itoa_pkg::NumDigits-1];
	assign final_digit = (rem_q == itoa_pkg::RemWidth'(1));

	// Sequencer and output register; a leading zero costs a scan step but no request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			dig_q       <= '0;
			rem_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (advance) begin
						out_valid_q <= 1'b0;
					end
					if (res.valid) begin
						dig_q     <= res.digits;
						rem_q     <= itoa_pkg::RemWidth'(itoa_pkg::NumDigits);
						started_q <= 1'b0;
						state_q   <= res.neg ? SIGN : DIGIT;
					end
				end
				SIGN: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						char_q      <= itoa_pkg::CharMinus;
						last_q      <= 1'b0;
						state_q     <= DIGIT;
					end
				end
				DIGIT: begin
					if (advance) begin
						dig_q <= {dig_q[itoa_pkg::NumDigits-2:0], 4'd0};
						rem_q <= rem_q - 1'b1;
						if (started_q || head != 4'd0 || final_digit) begin
							out_valid_q <= 1'b1;
							char_q      <= itoa_pkg::CharZero + {4'd0, head};
							last_q      <= final_digit;
							started_q   <= 1'b1;
						end else begin
							out_valid_q <= 1'b0;
						end
						if (final_digit) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy      = (state_q != IDLE);
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	`ITOA_ASSERT_NOW(a_load_idle, res.valid, state_q == IDLE, "conversion arrived while busy")
	`ITOA_ASSERT_NOW(a_last_digit, out_valid_q && last_q, char_q != itoa_pkg::CharMinus,
		"sign marked as final character")
	`ITOA_ASSERT_NOW(a_digit_range, out_valid_q && char_q != itoa_pkg::CharMinus,
		char_q >= itoa_pkg::CharZero && char_q <= itoa_pkg::CharZero + 8'd9,
		"character out of digit range")

endmodule

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Flow: the BCD converter shifts in the magnitude bit by bit and hands its result to the
// serializer, which sends the sign (if negative) and then scans the ten digit positions.
// One number at a time; leading zeros take a scan step each, output stalls hold the scan.
// Reset: arst_n asynchronously clears the sequencers and the output valid.
module signed_int_to_decimal_ascii_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [itoa_pkg::ValueWidth-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      char_code,
	output logic                            last_char
);

	logic                            accept;
	logic                            neg;
	logic [itoa_pkg::ValueWidth-1:0] mag;
	logic                            bcd_busy;
	logic                            emit_busy;
	itoa_pkg::bcd_res_t              res;

	// One number in flight at a time; the final character may still wait at the output.
	assign in_stall = bcd_busy | emit_busy;
	assign accept   = in_valid && !in_stall;

	// Magnitude in unsigned arithmetic also covers the most negative value.
	assign neg = value[itoa_pkg::ValueWidth-1];
	assign mag = neg ? (~value + 1'b1) : value;

	itoa_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.neg    (neg),
		.mag    (mag),
		.busy   (bcd_busy),
		.res    (res)
	);

	itoa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the signed integer to decimal ASCII text converter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumDirected  = 22;
	localparam int NumRandom    = 338;
	localparam int DrainCycles  = 64;
	localparam int IdleLimit    = 2000;
	localparam int ReportLimit  = 10;

	// One expected character of a number's text.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	typedef enum logic [1:0] {StallNever, StallRandom, StallRuns, StallToggle} stall_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [31:0] value     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  char_code;
	logic        last_char;

	text_char_t  expected_chars [$];
	int          error_count     = 0;
	int          chars_checked   = 0;
	int          numbers_sent    = 0;
	int          negatives_sent  = 0;
	int          idle_cycles     = 0;
	int          stall_cycle     = 0;
	int          stall_run       = 0;
	stall_mode_t stall_mode      = StallNever;

	int unsigned powers_of_ten [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
		10000000, 100000000, 1000000000};

	// Directed requests; an empty text means the predictor supplies the characters.
	logic [31:0] directed_values [NumDirected] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'sd999999999, 32'sd1000000000,
		-32'sd999999999, -32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'sd123456789, -32'sd987654321, 32'sd5, -32'sd100, 32'sd4096
	};
	string directed_texts [NumDirected] = '{
		"0", "1", "-1", "9", "10", "", "", "",
		"2147483647", "-2147483648", "-2147483647", "", "1000000000",
		"", "", "", "",
		"", "", "", "", ""
	};

	signed_int_to_decimal_ascii_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Predict the decimal text of a two's complement number, sign first.
	function automatic void queue_decimal_text(input logic [31:0] number);
		logic [31:0] magnitude;
		logic [3:0]  digit_list [10];
		int          count;
		magnitude = number[31] ? -number : number;
		count = 0;
		do begin
			digit_list[count] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			count++;
		end while (magnitude != 0);
		if (number[31]) begin
			expected_chars.push_back(text_char_t'{itoa_pkg::CharMinus, 1'b0});
		end
		for (int k = count - 1; k >= 0; k--) begin
			expected_chars.push_back(text_char_t'{itoa_pkg::CharZero + 8'(digit_list[k]),
				k == 0});
		end
	endfunction

	// Queue a text that is known by inspection.
	function automatic void queue_typed_text(input string text);
		for (int k = 0; k < text.len(); k++) begin
			expected_chars.push_back(text_char_t'{text[k], k == text.len() - 1});
		end
	endfunction

	// Random numbers biased toward digit-count boundaries and the extremes.
	function automatic logic [31:0] random_number();
		logic [31:0] magnitude;
		int          digits;
		magnitude = '0;
		digits = $urandom_range(1, 9);
		case ($urandom_range(0, 3))
			0: begin
				return $urandom;
			end
			1: begin
				magnitude = $urandom % powers_of_ten[digits];
			end
			2: begin
				magnitude = powers_of_ten[digits] + $urandom_range(0, 2) - 1;
			end
			default: begin
				magnitude = 32'h8000_0000 - $urandom_range(0, 3);
			end
		endcase
		return ($urandom_range(0, 1) != 0) ? -magnitude : magnitude;
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic [31:0] number, input string text);
		@(negedge clk);
		in_valid <= 1'b1;
		value    <= number;
		do begin
			@(posedge clk);
		end while (!(in_valid && !in_stall));
		if (text.len() != 0) begin
			queue_typed_text(text);
		end else begin
			queue_decimal_text(number);
		end
		numbers_sent++;
		if (number[31]) begin
			negatives_sent++;
		end
	endtask

	// Drop valid for a number of cycles with noise on the payload.
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		value    <= $urandom;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stimulus: reset, directed table, random bursts, then drain and verdict.
	initial begin
		int          burst_left;
		logic [31:0] number;
		string       text;
		burst_left = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NumDirected + NumRandom; i++) begin
			if (i < NumDirected) begin
				number = directed_values[i];
				text   = directed_texts[i];
			end else begin
				number = random_number();
				text   = "";
			end
			// Every third stretch of sixty requests runs back to back.
			if ((i / 60) % 3 != 1) begin
				if (burst_left == 0) begin
					idle_sender($urandom_range(1, 15));
					burst_left = $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
			send_request(number, text);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Converted %0d numbers (%0d negative, directed extremes included).",
			numbers_sent, negatives_sent);
		$display("Checked %0d characters; %0d errors.", chars_checked, error_count);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Receiver stall pattern; the stall_cycle counter sets when the mode is redrawn at random.
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 256 == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		end
		case (stall_mode)
			StallNever: begin
				out_stall <= 1'b0;
			end
			StallRandom: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			StallRuns: begin
				if (stall_run != 0) begin
					stall_run--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 5) == 0) begin
						stall_run = $urandom_range(1, 8);
					end
				end
			end
			default: begin
				out_stall <= ~out_stall;
			end
		endcase
	end

	// Compare each accepted character with the oldest expectation.
	always @(posedge clk) begin
		text_char_t wanted;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				error_count++;
				if (error_count <= ReportLimit) begin
					$display("Unexpected character 0x%02h last=%0b at %0t",
						char_code, last_char, $realtime);
				end
			end else begin
				wanted = expected_chars.pop_front();
				chars_checked++;
				if (char_code !== wanted.code || last_char !== wanted.last) begin
					error_count++;
					if (error_count <= ReportLimit) begin
						$display("Character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
							chars_checked, wanted.code, wanted.last, char_code, last_char);
					end
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == IdleLimit) begin
			$display("Timeout: no request or character accepted for %0d cycles.", IdleLimit);
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
